[design/dri_pkg.sv]
// ---------------------------------------------------------------------------
// dri_pkg: shared types and constants of the distance to strength interpolator
// Widths, region codes and the command and status structs that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package dri_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DIST_W      = 20;
  localparam int STR_W       = 16;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 1;
  localparam int NUM_W       = STR_W + DIST_W + 1;
  localparam int DEN_W       = DIST_W + 1;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

  localparam logic [STR_W-1:0] STR_MAX = {STR_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES     = 1'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REGION_INSIDE  = 2'd0,
    REGION_BELOW   = 2'd1,
    REGION_EXTRAP  = 2'd2,
    REGION_CLAMPED = 2'd3
  } region_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load;      // write a breakpoint
    logic             start;     // capture query, point read address at 0
    logic             rd_next;   // advance read address
    logic             seg_check; // set up interpolation over registered pair
    logic             extrap;    // set up extrapolation from last entry
    logic             div_start; // launch the divider
    logic             finish;    // form the result from the quotient
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic             below;     // query below the first breakpoint
    logic             hit;       // query falls inside the checked segment
    logic             equal;     // range limit equals last distance
    logic             div_done;
  } dp_sts_t;

endpackage

[design/dri_divider.sv]
// ---------------------------------------------------------------------------
// dri_divider: unsigned restoring divider
// One quotient bit per cycle.
// ---------------------------------------------------------------------------
module dri_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dri_pkg::NUM_W-1:0]   num,
  input  logic [dri_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [dri_pkg::NUM_W-1:0]   quot
);

  logic [dri_pkg::NUM_W-1:0]     q_r, q_nxt;
  logic [dri_pkg::DEN_W:0]       rem_r, rem_nxt;
  logic [dri_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [dri_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [dri_pkg::DEN_W:0]       trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[dri_pkg::DEN_W-1:0], q_r[dri_pkg::NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = dri_pkg::DIV_CNT_W'(dri_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[dri_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[dri_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dri_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[design/dri_datapath.sv]
// ---------------------------------------------------------------------------
// dri_datapath: breakpoint memory, segment compare and result arithmetic
// Holds the table in a memory with one registered read port, walks it one
// entry a cycle under controller command, and forms the output value.
// ---------------------------------------------------------------------------
module dri_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dri_pkg::dp_cmd_t             cmd,
  input  logic [dri_pkg::IDX_W-1:0]    wr_idx,
  input  logic [dri_pkg::DIST_W-1:0]   wr_dist,
  input  logic [dri_pkg::STR_W-1:0]    wr_str,
  input  logic [dri_pkg::DIST_W-1:0]   query,
  input  logic [dri_pkg::DIST_W-1:0]   range_limit,
  input  logic [dri_pkg::IDX_W-1:0]    last_idx,
  output dri_pkg::dp_sts_t             sts,
  output logic [dri_pkg::STR_W-1:0]    res_strength,
  output dri_pkg::region_t             res_region
);

  logic [dri_pkg::DIST_W-1:0] mem_d [dri_pkg::TABLE_DEPTH];
  logic [dri_pkg::STR_W-1:0]  mem_s [dri_pkg::TABLE_DEPTH];

  logic [dri_pkg::IDX_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [dri_pkg::DIST_W-1:0] rd_d_r, prev_d_r;
  logic [dri_pkg::STR_W-1:0]  rd_s_r, prev_s_r;
  logic [dri_pkg::DIST_W-1:0] q_r;
  logic [dri_pkg::STR_W-1:0]  sa_r;
  logic                       neg_r, ext_r;
  logic [dri_pkg::NUM_W-1:0]  num_r;
  logic [dri_pkg::DEN_W-1:0]  den_r;
  logic                       div_done;
  logic [dri_pkg::NUM_W-1:0]  quot;

  // Registered read; prev keeps the entry before the current one.
  always_comb begin
    rd_addr_nxt = rd_addr_r;
    if (cmd.start)        rd_addr_nxt = '0;
    else if (cmd.extrap)  rd_addr_nxt = last_idx;
    else if (cmd.rd_next) rd_addr_nxt = rd_addr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_d[wr_idx] <= wr_dist;
      mem_s[wr_idx] <= wr_str;
    end
    rd_d_r   <= mem_d[rd_addr_nxt];
    rd_s_r   <= mem_s[rd_addr_nxt];
    prev_d_r <= rd_d_r;
    prev_s_r <= rd_s_r;
    if (cmd.start) q_r <= query;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_addr_r <= '0;
    else        rd_addr_r <= rd_addr_nxt;
  end

  assign sts.below = q_r < rd_d_r;
  assign sts.hit   = (q_r >= prev_d_r) && (q_r < rd_d_r);
  assign sts.equal = range_limit == rd_d_r;

  // Operand setup: magnitudes of the product and divisor plus the sign.
  logic [dri_pkg::STR_W:0]    ds;
  logic [dri_pkg::DIST_W:0]   dd;
  logic [dri_pkg::DIST_W:0]   den_e;
  logic                       s_neg, d_neg, r_neg;
  logic [dri_pkg::STR_W-1:0]  ds_mag;
  logic [dri_pkg::DIST_W-1:0] dd_mag, den_mag;

  always_comb begin
    if (cmd.seg_check) begin
      ds    = {1'b0, prev_s_r} - {1'b0, rd_s_r};
      dd    = {1'b0, q_r} - {1'b0, prev_d_r};
      den_e = {1'b0, rd_d_r} - {1'b0, prev_d_r};
    end else begin
      ds    = {1'b0, rd_s_r};
      dd    = {1'b0, q_r} - {1'b0, rd_d_r};
      den_e = {1'b0, range_limit} - {1'b0, rd_d_r};
    end
    s_neg   = ds[dri_pkg::STR_W];
    d_neg   = dd[dri_pkg::DIST_W];
    r_neg   = den_e[dri_pkg::DIST_W];
    ds_mag  = s_neg ? dri_pkg::STR_W'(-ds) : ds[dri_pkg::STR_W-1:0];
    dd_mag  = d_neg ? dri_pkg::DIST_W'(-dd) : dd[dri_pkg::DIST_W-1:0];
    den_mag = r_neg ? dri_pkg::DIST_W'(-den_e) : den_e[dri_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_check || cmd.extrap) begin
      num_r <= dri_pkg::NUM_W'(ds_mag) * dri_pkg::NUM_W'(dd_mag);
      den_r <= {1'b0, den_mag};
      neg_r <= s_neg ^ d_neg ^ r_neg;
      sa_r  <= cmd.seg_check ? prev_s_r : rd_s_r;
      ext_r <= cmd.extrap;
    end
  end

  dri_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign sts.div_done = div_done;

  // val = sa - q with q signed by neg_r.
  logic [dri_pkg::NUM_W+1:0] val;
  always_comb begin
    if (neg_r) val = {2'b0, quot} + (dri_pkg::NUM_W+2)'(sa_r);
    else       val = (dri_pkg::NUM_W+2)'(sa_r) - {2'b0, quot};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (val[dri_pkg::NUM_W+1]) begin
        res_strength <= '0;
        res_region   <= ext_r ? dri_pkg::REGION_CLAMPED : dri_pkg::REGION_INSIDE;
      end else begin
        res_strength <= (val > (dri_pkg::NUM_W+2)'(dri_pkg::STR_MAX)) ? dri_pkg::STR_MAX
                        : val[dri_pkg::STR_W-1:0];
        res_region   <= ext_r ? dri_pkg::REGION_EXTRAP : dri_pkg::REGION_INSIDE;
      end
    end
  end

endmodule

[design/dri_controller.sv]
// ---------------------------------------------------------------------------
// dri_controller: request sequencer
// Takes requests, steps the table walk, launches the divider and holds
// the result in an output register until it is taken.
// ---------------------------------------------------------------------------
module dri_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  input  logic                        req_type,
  output logic                        req_ready,
  output logic                        res_valid,
  input  logic                        res_ready,
  input  logic [dri_pkg::CNT_W-1:0]   n_used,
  input  dri_pkg::dp_sts_t            sts,
  input  logic [dri_pkg::STR_W-1:0]   dp_strength,
  input  dri_pkg::region_t            dp_region,
  output dri_pkg::dp_cmd_t            cmd,
  output logic [dri_pkg::STR_W-1:0]   out_strength,
  output dri_pkg::region_t            out_region
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIRST = 7'b0000010,
    S_CHK0  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_EXT   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [dri_pkg::CNT_W-1:0] i_r, i_nxt;
  logic                      ov_r, ov_nxt;
  logic                      early_r, early_nxt;
  dri_pkg::region_t          early_reg_r, early_reg_nxt;
  logic [dri_pkg::STR_W-1:0] early_str_r, early_str_nxt;
  logic                      fin_d_r;
  logic [dri_pkg::STR_W-1:0] ostr_r, ostr_nxt;
  dri_pkg::region_t          oreg_r, oreg_nxt;
  logic                      accept;

  // The cycle after finish still moves the result into the output register.
  assign req_ready = (state_r == S_IDLE) && !ov_r && !fin_d_r;
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    early_nxt     = early_r;
    early_reg_nxt = early_reg_r;
    early_str_nxt = early_str_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_type == dri_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            early_nxt = 1'b0;
            state_nxt = S_FIRST;
          end
        end
      end
      // Read address stays on entry 0, so the next cycle still sees it.
      S_FIRST: begin
        i_nxt       = dri_pkg::CNT_W'(1);
        state_nxt   = S_CHK0;
      end
      S_CHK0: begin
        if (sts.below) begin
          early_nxt     = 1'b1;
          early_str_nxt = dri_pkg::STR_MAX;
          early_reg_nxt = dri_pkg::REGION_BELOW;
          state_nxt     = S_FIN;
        end else if (i_r >= n_used) begin
          cmd.extrap = 1'b1;
          state_nxt  = S_EXT;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      // Registered pair is entries i-1 and i.
      S_WALK: begin
        if (sts.hit) begin
          cmd.seg_check = 1'b1;
          state_nxt     = S_DIV;
        end else if (i_r + 1'b1 >= n_used) begin
          cmd.extrap = 1'b1;
          state_nxt  = S_EXT;
        end else begin
          cmd.rd_next = 1'b1;
          i_nxt       = i_r + 1'b1;
        end
      end
      // The last entry read is registered on entry to this state.
      S_EXT: begin
        if (sts.equal) begin
          early_nxt     = 1'b1;
          early_str_nxt = '0;
          early_reg_nxt = dri_pkg::REGION_CLAMPED;
          state_nxt     = S_FIN;
        end else begin
          cmd.extrap = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (early_r) begin
          state_nxt = S_IDLE;
        end else if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: loaded from the early path or in the cycle after finish.
  always_comb begin
    ov_nxt   = ov_r;
    ostr_nxt = ostr_r;
    oreg_nxt = oreg_r;
    if (res_valid && res_ready) ov_nxt = 1'b0;
    if (state_r == S_FIN && early_r) begin
      ov_nxt   = 1'b1;
      ostr_nxt = early_str_r;
      oreg_nxt = early_reg_r;
    end
    if (fin_d_r) begin
      ov_nxt   = 1'b1;
      ostr_nxt = dp_strength;
      oreg_nxt = dp_region;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      fin_d_r <= 1'b0;
      early_r <= 1'b0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      fin_d_r <= cmd.finish;
      early_r <= early_nxt;
      i_r     <= i_nxt;
    end
    early_reg_r <= early_reg_nxt;
    early_str_r <= early_str_nxt;
    ostr_r      <= ostr_nxt;
    oreg_r      <= oreg_nxt;
  end

  assign res_valid    = ov_r;
  assign out_strength = ostr_r;
  assign out_region   = oreg_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !req_ready)
    else $error("request accepted while a query is in flight");
  a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(out_strength)))
    else $error("result changed while waiting");
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> ##1 res_valid)
    else $error("finished query did not reach the output");

endmodule

[design/distance_to_rssi_interpolator_core.sv]
// ---------------------------------------------------------------------------
// distance_to_rssi_interpolator_core: piecewise linear distance to strength
// Loads breakpoints into a table and converts query distances by a linear
// segment search and an interpolation through an iterative divider.
// ---------------------------------------------------------------------------
//  channel | direction | content
//  in_     | slave     | tdata = entry_index, entry_distance, entry_strength,
//          |           |         query_distance; tuser = req_type
//  out_    | master     | tdata = strength, region
//  cfg_    | write     | 0 range_limit, 1 entries_in_use
//
// A load request writes one table entry. A query walks the breakpoints, one
// memory read per cycle, until its segment is found, then runs the 37-step
// one-bit-per-cycle divider and passes through the two result register stages.
// Reset is synchronous and active low; the table contents are undefined
// until loaded. While a result waits in the output register, no new request
// is taken; the block works on one request at a time.
module distance_to_rssi_interpolator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] entry_index, [25:6] entry_distance, [41:26] entry_strength,
  // [61:42] query_distance, [63:62] zero
  input  logic [63:0] in_tdata,
  // [0] req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] strength, [17:16] region, [23:18] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [dri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dri_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [dri_pkg::DIST_W-1:0] range_limit_r;
  logic [6:0]                 entries_r;
  logic [dri_pkg::CNT_W-1:0]  n_used;
  logic [dri_pkg::IDX_W-1:0]  last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r <= dri_pkg::DIST_W'(12800);
      entries_r     <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dri_pkg::REG_RANGE_LIMIT: range_limit_r <= cfg_wdata;
        dri_pkg::REG_ENTRIES:     entries_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Clamp the entry count into 1..TABLE_DEPTH.
  always_comb begin
    if (entries_r == 7'd0) n_used = dri_pkg::CNT_W'(1);
    else if (entries_r > 7'(dri_pkg::TABLE_DEPTH)) n_used = dri_pkg::CNT_W'(dri_pkg::TABLE_DEPTH);
    else n_used = dri_pkg::CNT_W'(entries_r);
  end
  assign last_idx = dri_pkg::IDX_W'(n_used - 1'b1);

  dri_pkg::dp_cmd_t  cmd;
  dri_pkg::dp_sts_t  sts;
  logic [dri_pkg::STR_W-1:0] dp_str, o_str;
  dri_pkg::region_t  dp_reg, o_reg;

  dri_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_tvalid),
    .req_type     (in_tuser),
    .req_ready    (in_tready),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .n_used       (n_used),
    .sts          (sts),
    .dp_strength  (dp_str),
    .dp_region    (dp_reg),
    .cmd          (cmd),
    .out_strength (o_str),
    .out_region   (o_reg)
  );

  dri_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .wr_idx       (in_tdata[5:0]),
    .wr_dist      (in_tdata[25:6]),
    .wr_str       (in_tdata[41:26]),
    .query        (in_tdata[61:42]),
    .range_limit  (range_limit_r),
    .last_idx     (last_idx),
    .sts          (sts),
    .res_strength (dp_str),
    .res_region   (dp_reg)
  );

  assign out_tdata = {6'd0, o_reg, o_str};

endmodule
